[rtl/core/gss_pkg.sv]
// Package for the 3x3 grid stencil smoother: sizes, config register codes,
// beat structs and the control structs passed between the pipeline modules.
// Depends on nothing; every other file of the block but gss_ram imports it.
`default_nettype none
package gss_pkg;

  // Largest interior side and sample precision.
  localparam int MAX_INNER   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 16;
  // Row and column fields are 13 bits wide, so MAX_INNER stays within 8189.
  localparam int POS_BITS    = 13;

  // Line memory: one entry per padded column, upper and middle row packed.
  localparam int LINE_DEPTH = MAX_INNER + 2;
  localparam int ADDR_BITS  = $clog2(LINE_DEPTH);
  localparam int LINE_BITS  = 2 * SAMPLE_BITS;

  // Datapath widths: four-sample sums, weighted products, accumulator.
  localparam int SUM_BITS   = SAMPLE_BITS + 2;
  localparam int PROD_BITS  = SUM_BITS + WEIGHT_BITS;
  localparam int CPROD_BITS = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_BITS   = PROD_BITS + 2;
  localparam int RND_BITS   = ACC_BITS - WEIGHT_BITS;
  localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (WEIGHT_BITS - 1);

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CORNER = 2'd0,
    CFG_EDGE   = 2'd1,
    CFG_CENTRE = 2'd2,
    CFG_INNER  = 2'd3
  } cfg_idx_t;

  localparam logic [WEIGHT_BITS-1:0] CORNER_RESET = 16'd3277;
  localparam logic [WEIGHT_BITS-1:0] EDGE_RESET   = 16'd6554;
  localparam logic [WEIGHT_BITS-1:0] CENTRE_RESET = 16'd26214;
  localparam logic [POS_BITS-1:0]    INNER_RESET  = POS_BITS'(MAX_INNER);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   frame_start;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] smoothed;
    logic [POS_BITS-1:0]    out_row;
    logic [POS_BITS-1:0]    out_col;
    logic                   frame_last;
  } out_item_t;

  // Position of one sample, worked out when the beat is taken.
  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [POS_BITS-1:0]  row;
    logic [POS_BITS-1:0]  col;
    logic                 produce;
    logic                 last;
  } pos_t;

  // Neighbourhood sums handed to the multiply stage.
  typedef struct packed {
    logic [SUM_BITS-1:0]    diag;
    logic [SUM_BITS-1:0]    direct;
    logic [SAMPLE_BITS-1:0] centre;
    logic [POS_BITS-1:0]    row;
    logic [POS_BITS-1:0]    col;
    logic                   last;
  } sums_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] corner_w;
    logic [WEIGHT_BITS-1:0] edge_w;
    logic [WEIGHT_BITS-1:0] centre_w;
  } weights_t;

endpackage
`default_nettype wire

[rtl/core/grid_stencil_smoother_3x3.sv]
// Top level of the 3x3 grid stencil smoother: configuration registers, line
// memory and the raster, window and weighting stages. Uses gss_pkg.
//
// Usage:
//   smp channel   - one padded grid sample per beat, raster order; frame_start
//                   marks the top-left padding sample and restarts the position.
//   res channel   - one beat per interior point: smoothed value (rounded half
//                   up, saturated), interior row and column, frame_last on the
//                   last interior point of the grid. Padding beats give none.
//   cfg channel   - cfg_index selects corner, edge, centre weight or inner
//                   size; always ready. Write only while the block is idle.
// Throughput: one sample per cycle while the receiver keeps up. The line memory is
//   read at the column of a beat on accept and written when that beat leaves the
//   window stage; a read that meets the write to the same column is forwarded.
// Path: a result passes the window stage, which loads on the edge that accepts
//   its sample, then the multiply stage and the output register.
// Reset: clears the position, the window and all valid flags and loads the
//   default weights and size; the line memory is not cleared and needs no pass.
// Stall: a stalled receiver holds the output beat; the stages behind it fill,
//   then smp_ready drops. Padding samples keep flowing until an interior
//   sample waits in the window stage.
`default_nettype none
module grid_stencil_smoother_3x3 (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               smp_valid,
  output logic                                    smp_ready,
  input  wire gss_pkg::in_item_t                  smp,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output gss_pkg::out_item_t                      res,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [gss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [gss_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import gss_pkg::*;

  weights_t             weights;
  logic [POS_BITS-1:0]  inner_size;
  logic                 accept;
  pos_t                 pos;
  logic [LINE_BITS-1:0] rd_data, wr_data;
  logic [ADDR_BITS-1:0] wr_addr;
  logic                 wr_en;
  logic                 sums_valid, mac_ready;
  sums_t                sums;

  assign cfg_ready = 1'b1;
  assign accept    = smp_valid && smp_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      weights.corner_w <= CORNER_RESET;
      weights.edge_w   <= EDGE_RESET;
      weights.centre_w <= CENTRE_RESET;
      inner_size       <= INNER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CORNER: weights.corner_w <= cfg_data[WEIGHT_BITS-1:0];
        CFG_EDGE:   weights.edge_w   <= cfg_data[WEIGHT_BITS-1:0];
        CFG_CENTRE: weights.centre_w <= cfg_data[WEIGHT_BITS-1:0];
        CFG_INNER:  inner_size       <= cfg_data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  gss_raster u_raster (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .smp        (smp),
    .inner_size (inner_size),
    .pos        (pos)
  );

  // Upper and middle rows share one word per padded column.
  gss_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (pos.addr),
    .rdata (rd_data)
  );

  gss_window u_window (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .smp        (smp),
    .pos        (pos),
    .smp_ready  (smp_ready),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .sums_valid (sums_valid),
    .mac_ready  (mac_ready),
    .sums       (sums)
  );

  gss_mac u_mac (
    .clk        (clk),
    .rst        (rst),
    .sums_valid (sums_valid),
    .sums       (sums),
    .mac_ready  (mac_ready),
    .weights    (weights),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule
`default_nettype wire

[rtl/core/gss_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the line memory of the smoother.
`default_nettype none
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4098
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word; hold it while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/gss_raster.sv]
// Raster position tracker: row and column of each incoming sample, line
// memory address, interior flag and last-point flag. Uses gss_pkg.
`default_nettype none
module gss_raster (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire gss_pkg::in_item_t             smp,
  input  wire logic [gss_pkg::POS_BITS-1:0]  inner_size,
  output gss_pkg::pos_t                      pos
);
  import gss_pkg::*;

  logic [POS_BITS-1:0] row_pos, col_pos;
  logic [POS_BITS-1:0] row_pos_next, col_pos_next;
  logic [POS_BITS-1:0] eff, side;
  logic [POS_BITS:0]   side_w, r, c, r_n, c_n;
  logic [POS_BITS-1:0] r_int, c_int;

  // Clamp the interior size and add the padding ring.
  always_comb begin
    if (inner_size == '0) begin
      eff = POS_BITS'(1);
    end else if (inner_size > POS_BITS'(MAX_INNER)) begin
      eff = POS_BITS'(MAX_INNER);
    end else begin
      eff = inner_size;
    end
    side   = eff + POS_BITS'(2);
    side_w = {1'b0, side};
  end

  // Position of this beat: restart on frame_start, wrap a stale position.
  always_comb begin
    if (smp.frame_start) begin
      r = '0;
      c = '0;
    end else begin
      r = {1'b0, row_pos};
      c = {1'b0, col_pos};
      if (c >= side_w) begin
        c = '0;
        r = r + 1'b1;
      end
      if (r >= side_w) begin
        r = '0;
      end
    end
  end

  // Advance to the next raster point.
  always_comb begin
    c_n = c + 1'b1;
    r_n = r;
    if (c_n >= side_w) begin
      c_n = '0;
      r_n = r + 1'b1;
      if (r_n >= side_w) begin
        r_n = '0;
      end
    end
    row_pos_next = r_n[POS_BITS-1:0];
    col_pos_next = c_n[POS_BITS-1:0];
  end

  // Interior indices and flags; the window centre sits one row and column back.
  always_comb begin
    r_int       = r[POS_BITS-1:0] - 1'b1;
    c_int       = c[POS_BITS-1:0] - 1'b1;
    pos.addr    = c[ADDR_BITS-1:0];
    pos.row     = r_int;
    pos.col     = c_int;
    pos.produce = (r >= (POS_BITS+1)'(2)) && (c >= (POS_BITS+1)'(2));
    pos.last    = (r == side_w - 1'b1) && (c == side_w - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (accept) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  a_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && smp.frame_start |=> row_pos == '0 && col_pos == POS_BITS'(1))
    else $error("position after frame_start is not row 0, column 1");

  a_last_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && pos.last |=> row_pos == '0 && col_pos == '0)
    else $error("position did not wrap after the last grid point");

endmodule
`default_nettype wire

[rtl/core/gss_window.sv]
// Window stage: takes the line memory word, forwards a write to the same
// column, writes the shifted rows back, keeps the 3x3 window and forms the
// diagonal and direct sums. Uses gss_pkg.
`default_nettype none
module gss_window (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            accept,
  input  wire gss_pkg::in_item_t               smp,
  input  wire gss_pkg::pos_t                   pos,
  output logic                                 smp_ready,
  input  wire logic [gss_pkg::LINE_BITS-1:0]   rd_data,
  output logic                                 wr_en,
  output logic      [gss_pkg::ADDR_BITS-1:0]   wr_addr,
  output logic      [gss_pkg::LINE_BITS-1:0]   wr_data,
  output logic                                 sums_valid,
  input  wire logic                            mac_ready,
  output gss_pkg::sums_t                       sums
);
  import gss_pkg::*;

  logic                   s1_valid;
  pos_t                   s1_pos;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   fwd_hit;
  logic [LINE_BITS-1:0]   fwd_data;
  logic [SAMPLE_BITS-1:0] win [6];
  logic                   s1_fire;
  logic [LINE_BITS-1:0]   line;
  logic [SAMPLE_BITS-1:0] up, mid;

  // Interior beats wait for the multiply stage; padding beats just pass.
  assign s1_fire    = s1_valid && (!s1_pos.produce || mac_ready);
  assign smp_ready  = !s1_valid || s1_fire;
  assign sums_valid = s1_valid && s1_pos.produce;

  // Take the word just written when the read raced the write to one column.
  assign line = fwd_hit ? fwd_data : rd_data;
  assign up   = line[LINE_BITS-1:SAMPLE_BITS];
  assign mid  = line[SAMPLE_BITS-1:0];

  // Shift the rows down one line in memory.
  assign wr_en   = s1_fire;
  assign wr_addr = s1_pos.addr;
  assign wr_data = {mid, s1_sample};

  // Diagonal and direct neighbour sums around the window centre.
  always_comb begin
    sums.diag   = SUM_BITS'(win[0]) + SUM_BITS'(win[2]) + SUM_BITS'(up)
                + SUM_BITS'(s1_sample);
    sums.direct = SUM_BITS'(win[1]) + SUM_BITS'(win[3]) + SUM_BITS'(win[5])
                + SUM_BITS'(mid);
    sums.centre = win[4];
    sums.row    = s1_pos.row;
    sums.col    = s1_pos.col;
    sums.last   = s1_pos.last;
  end

  // Stage occupancy, forward flag and window columns.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_fire && (s1_pos.addr == pos.addr);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
        fwd_hit  <= 1'b0;
      end
      if (s1_fire) begin
        win[0] <= win[3];
        win[1] <= win[4];
        win[2] <= win[5];
        win[3] <= up;
        win[4] <= mid;
        win[5] <= s1_sample;
      end
    end
  end

  // Hold the beat payload and the word being written.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos    <= pos;
      s1_sample <= smp.sample;
      fwd_data  <= {mid, s1_sample};
    end
  end

  a_fwd_occupied: assert property (@(posedge clk) disable iff (rst)
    fwd_hit |-> s1_valid)
    else $error("forward flag set with the window stage empty");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_pos))
    else $error("window stage lost or changed a stalled beat");

endmodule
`default_nettype wire

[rtl/core/gss_mac.sv]
// Weighting stage: three products, then round half up, saturate and hold
// the result beat in the output register. Uses gss_pkg.
`default_nettype none
module gss_mac (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sums_valid,
  input  wire gss_pkg::sums_t     sums,
  output logic                    mac_ready,
  input  wire gss_pkg::weights_t  weights,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output gss_pkg::out_item_t      res
);
  import gss_pkg::*;

  logic                   s2_valid;
  logic [PROD_BITS-1:0]   prod_diag, prod_direct;
  logic [CPROD_BITS-1:0]  prod_centre;
  logic [POS_BITS-1:0]    s2_row, s2_col;
  logic                   s2_last;
  logic                   s3_ready, s2_adv;
  logic [ACC_BITS-1:0]    acc;
  logic [RND_BITS-1:0]    rounded;
  logic [SAMPLE_BITS-1:0] sat;

  assign s3_ready  = !res_valid || res_ready;
  assign mac_ready = !s2_valid || s3_ready;
  assign s2_adv    = s2_valid && s3_ready;

  // Sum the products, round half up, clip at full scale.
  always_comb begin
    acc = ACC_BITS'(prod_diag) + ACC_BITS'(prod_direct) + ACC_BITS'(prod_centre)
        + ROUND_HALF;
    rounded = acc[ACC_BITS-1:WEIGHT_BITS];
    if (rounded[RND_BITS-1:SAMPLE_BITS] != '0) begin
      sat = '1;
    end else begin
      sat = rounded[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (mac_ready) begin
        s2_valid <= sums_valid;
      end
      if (s3_ready) begin
        res_valid <= s2_valid;
      end
    end
  end

  // Multiply, then hold the finished beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (mac_ready && sums_valid) begin
      prod_diag   <= PROD_BITS'(sums.diag) * PROD_BITS'(weights.corner_w);
      prod_direct <= PROD_BITS'(sums.direct) * PROD_BITS'(weights.edge_w);
      prod_centre <= CPROD_BITS'(sums.centre) * CPROD_BITS'(weights.centre_w);
      s2_row      <= sums.row;
      s2_col      <= sums.col;
      s2_last     <= sums.last;
    end
    if (s2_adv) begin
      res.smoothed   <= sat;
      res.out_row    <= s2_row;
      res.out_col    <= s2_col;
      res.frame_last <= s2_last;
    end
  end

  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s3_ready |=> s2_valid && $stable(prod_diag) && $stable(prod_direct))
    else $error("multiply stage changed while the output was stalled");

endmodule
`default_nettype wire
